[src/cse_pkg.sv]
// ----------------------------------------------------------------------------
// cse_pkg
// Shared constants and types for the counting sort engine.
// ----------------------------------------------------------------------------
package cse_pkg;

   localparam int VALUE_BITS = 8;
   localparam int NUM_BINS   = 1 << VALUE_BITS;
   localparam int MAX_ITEMS  = 64;
   localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
   localparam int HIST_BITS  = 7;
   localparam int IN_BITS    = 8;
   localparam int OUT_BITS   = 8;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int FILL_BITS  = $clog2(FIFO_DEPTH + 1);

   // one classified transaction as it travels from front to back
   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  last;
      logic                  drop;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INC,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_EMIT
   } state_type;

endpackage

[src/cse_front.sv]
// ----------------------------------------------------------------------------
// cse_front
// Accepts input transactions and marks those beyond capacity for dropping.
// ----------------------------------------------------------------------------
module cse_front
   import cse_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [IN_BITS-1:0] req_value,
   input  logic               req_last,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               q_not_full,
   output logic               q_push,
   output item_type           q_item
);

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                full;

   assign full      = (count_ff == CNT_BITS'(MAX_ITEMS));
   assign req_ready = q_not_full;
   assign q_push    = req_valid && q_not_full;

   always_comb begin
      q_item.value = VALUE_BITS'(req_value);
      q_item.last  = req_last;
      q_item.drop  = full;
   end

   // count restarts after the last transaction of a set
   always_comb begin
      count_in = count_ff;
      if (q_push) begin
         if (req_last)
            count_in = '0;
         else if (!full)
            count_in = count_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         count_ff <= '0;
      else
         count_ff <= count_in;
   end

endmodule

[src/cse_fifo.sv]
// ----------------------------------------------------------------------------
// cse_fifo
// Short queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
module cse_fifo
   import cse_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     not_full,
   input  logic     pop,
   output logic     not_empty,
   output item_type head
);

   item_type             store_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic                 do_push, do_pop;

   assign not_full  = (fill_ff != FILL_BITS'(FIFO_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign head      = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop)
         fill_in = fill_ff + FILL_BITS'(1);
      else if (do_pop && !do_push)
         fill_in = fill_ff - FILL_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         store_ff[wr_ptr_ff] <= push_item;
   end

endmodule

[src/cse_back.sv]
// ----------------------------------------------------------------------------
// cse_back
// Histogram load, bin scan and sorted emit, with the result register.
// ----------------------------------------------------------------------------
module cse_back
   import cse_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                q_not_empty,
   input  item_type            q_head,
   output logic                q_pop,
   output logic [OUT_BITS-1:0] rsp_value_res,
   output logic                rsp_last_res,
   output logic                rsp_dropped,
   output logic                rsp_valid,
   input  logic                rsp_ready
);

   state_type state_ff, state_in;

   logic [VALUE_BITS-1:0] min_ff, min_in;
   logic [VALUE_BITS-1:0] max_ff, max_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic [VALUE_BITS-1:0] item_ff, item_in;
   logic                  last_ff, last_in;
   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [HIST_BITS-1:0]  cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]   remain_ff, remain_in;

   logic                  out_valid_ff, out_valid_in;
   logic [OUT_BITS-1:0]   out_value_ff, out_value_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_drop_ff, out_drop_in;

   // histogram store; an entry whose valid bit is clear reads as zero
   logic [HIST_BITS-1:0]  hist_mem [NUM_BINS];
   logic                  hist_vld_ff [NUM_BINS];
   logic [HIST_BITS-1:0]  rd_data_ff;
   logic                  rd_vld_ff;
   logic [HIST_BITS-1:0]  hist;

   logic                  rd_en;
   logic [VALUE_BITS-1:0] rd_addr;
   logic                  wr_en;
   logic                  vld_clr;
   logic                  out_free;
   logic                  emit_fire;
   logic                  finish;

   assign hist      = rd_vld_ff ? rd_data_ff : '0;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign emit_fire = (state_ff == ST_EMIT) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               if (!q_head.drop)
                  state_in = ST_INC;
               else if (q_head.last && count_ff != '0)
                  state_in = ST_SCAN_RD;
            end
         end
         ST_INC: begin
            state_in = last_ff ? ST_SCAN_RD : ST_IDLE;
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (hist != '0)
               state_in = ST_EMIT;
            else if (bin_ff == max_ff)
               state_in = ST_IDLE;
            else
               state_in = ST_SCAN_RD;
         end
         ST_EMIT: begin
            if (out_free && cnt_ff == HIST_BITS'(1))
               state_in = (bin_ff == max_ff) ? ST_IDLE : ST_SCAN_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and control
   always_comb begin
      q_pop     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = bin_ff;
      wr_en     = 1'b0;
      vld_clr   = 1'b0;
      finish    = 1'b0;
      min_in    = min_ff;
      max_in    = max_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      item_in   = item_ff;
      last_in   = last_ff;
      bin_in    = bin_ff;
      cnt_in    = cnt_ff;
      remain_in = remain_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_drop_in  = out_drop_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               q_pop = 1'b1;
               if (!q_head.drop) begin
                  rd_en    = 1'b1;
                  rd_addr  = q_head.value;
                  item_in  = q_head.value;
                  last_in  = q_head.last;
                  count_in = count_ff + CNT_BITS'(1);
                  if (q_head.value < min_ff)
                     min_in = q_head.value;
                  if (q_head.value > max_ff)
                     max_in = q_head.value;
               end else begin
                  ovf_in = 1'b1;
                  if (q_head.last) begin
                     bin_in    = min_ff;
                     remain_in = count_ff;
                     // nothing loaded in this set: just clear it
                     if (count_ff == '0)
                        finish = 1'b1;
                  end
               end
            end
         end
         ST_INC: begin
            wr_en = 1'b1;
            if (last_ff) begin
               bin_in    = min_ff;
               remain_in = count_ff;
            end
         end
         ST_SCAN_RD: begin
            rd_en = 1'b1;
         end
         ST_SCAN_CHK: begin
            cnt_in  = hist;
            vld_clr = 1'b1;
            if (hist == '0) begin
               if (bin_ff == max_ff)
                  finish = 1'b1;
               else
                  bin_in = bin_ff + VALUE_BITS'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = OUT_BITS'(bin_ff);
               out_last_in  = (remain_ff == CNT_BITS'(1));
               out_drop_in  = ovf_ff;
               remain_in    = remain_ff - CNT_BITS'(1);
               cnt_in       = cnt_ff - HIST_BITS'(1);
               if (cnt_ff == HIST_BITS'(1)) begin
                  if (bin_ff == max_ff)
                     finish = 1'b1;
                  else
                     bin_in = bin_ff + VALUE_BITS'(1);
               end
            end
         end
         default: ;
      endcase

      if (finish) begin
         min_in   = '1;
         max_in   = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= '1;
         max_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      last_ff      <= last_in;
      bin_ff       <= bin_in;
      cnt_ff       <= cnt_in;
      remain_ff    <= remain_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_drop_ff  <= out_drop_in;
   end

   // histogram memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en)
         hist_mem[item_ff] <= hist + HIST_BITS'(1);
      if (rd_en)
         rd_data_ff <= hist_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset)
         rd_vld_ff <= 1'b0;
      else if (rd_en)
         rd_vld_ff <= hist_vld_ff[rd_addr];
   end

   // the scan empties every bin it passes, which clears the set
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++)
            hist_vld_ff[i] <= 1'b0;
      end else if (wr_en) begin
         hist_vld_ff[item_ff] <= 1'b1;
      end else if (vld_clr) begin
         hist_vld_ff[bin_ff] <= 1'b0;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_value_res = out_value_ff;
   assign rsp_last_res  = out_last_ff;
   assign rsp_dropped   = out_drop_ff;

`ifndef ASSERT_OFF
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_ITEMS))
      else $error("item count beyond capacity");

   a_bounds: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> min_ff <= max_ff)
      else $error("bounds inverted in a non-empty set");

   a_emit_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> cnt_ff != '0 && remain_ff != '0)
      else $error("emit with an empty bin or nothing remaining");

   a_final_clear: assert property (@(posedge clock) disable iff (reset)
      emit_fire && remain_ff == CNT_BITS'(1)
      |=> state_ff == ST_IDLE && count_ff == '0 && !ovf_ff)
      else $error("set not cleared after its final result");
`endif

endmodule

[src/counting_sort_engine_core.sv]
// ----------------------------------------------------------------------------
// counting_sort_engine_core
// Counting sort of unsigned values, one set at a time, results ascending.
// ----------------------------------------------------------------------------
// The front takes one input transaction per cycle into a four-entry queue
// while the queue has room, and marks those beyond 64 in a set for dropping.
// The back drains the queue: each loaded value is read and then its histogram
// bin incremented through the bin memory; a dropped one is only popped.
// After the last transaction the back scans bins from the set's minimum to
// its maximum, with a read and a check per bin and an emit per result.
// Results carry last_res on the final one and dropped if any transaction of
// that set was discarded. The histogram is empty straight out of reset; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module counting_sort_engine_core
   import cse_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [IN_BITS-1:0]  req_value,
   input  logic                req_last,
   input  logic                req_valid,
   output logic                req_ready,
   output logic [OUT_BITS-1:0] rsp_value_res,
   output logic                rsp_last_res,
   output logic                rsp_dropped,
   output logic                rsp_valid,
   input  logic                rsp_ready
);

   logic     q_push, q_not_full, q_pop, q_not_empty;
   item_type q_item, q_head;

   cse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_value),
      .req_last   (req_last),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .q_not_full (q_not_full),
      .q_push     (q_push),
      .q_item     (q_item)
   );

   cse_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   cse_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_value_res (rsp_value_res),
      .rsp_last_res  (rsp_last_res),
      .rsp_dropped   (rsp_dropped),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready)
   );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the counting sort engine core.
// ----------------------------------------------------------------------------
// Sets of unsigned values are pushed through the request channel. A monitor
// on accepted request transactions feeds a software histogram. On the closing
// transaction of a set it queues the ascending values the core should return.
// Each response transaction is checked against the oldest queued value. The
// stimulus runs through directed sets, an overflowing set sent against a long
// response stall, and three random phases with different idling on each side.
// ----------------------------------------------------------------------------
module tb_top;
   import cse_pkg::*;

   localparam int STALL_LIMIT = 4000;   // quiet cycles before giving up
   localparam int TAIL_CYCLES = 600;    // > one full 256-bin scan
   localparam int MAX_REPORTS = 10;

   typedef logic [IN_BITS-1:0] value_q_type[$];

   typedef struct {
      logic [OUT_BITS-1:0] value;
      logic                last;
      logic                dropped;
   } sorted_item_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic [IN_BITS-1:0]  req_value = '0;
   logic                req_last = 1'b0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OUT_BITS-1:0] rsp_value_res;
   logic                rsp_last_res;
   logic                rsp_dropped;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;

   // software copy of the sorter state
   logic [HIST_BITS-1:0]  bin_count [NUM_BINS];
   logic [VALUE_BITS-1:0] set_min = '1;
   logic [VALUE_BITS-1:0] set_max = '0;
   int unsigned           set_items = 0;
   logic                  set_overflow = 1'b0;

   sorted_item_type sorted_queue[$];
   int unsigned  sort_errors = 0;
   int unsigned  quiet_cycles = 0;
   int unsigned  req_idle_pct = 0;
   int unsigned  rsp_idle_pct = 0;
   int unsigned  hold_request = 0;
   int unsigned  hold_left = 0;

   counting_sort_engine_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .req_last      (req_last),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .rsp_value_res (rsp_value_res),
      .rsp_last_res  (rsp_last_res),
      .rsp_dropped   (rsp_dropped),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready)
   );

   always #2 clock = ~clock;

   initial begin
      foreach (bin_count[i]) bin_count[i] = '0;
   end

   // load one accepted value; on the closing one, queue the sorted set
   task automatic absorb_value(input logic [IN_BITS-1:0] raw, input logic closing);
      logic [VALUE_BITS-1:0] v;
      int unsigned           remaining;
      sorted_item_type       item;
      v = raw[VALUE_BITS-1:0];
      if (set_items < MAX_ITEMS) begin
         bin_count[v] = bin_count[v] + 1'b1;
         if (v < set_min) set_min = v;
         if (v > set_max) set_max = v;
         set_items++;
      end else begin
         set_overflow = 1'b1;
      end
      if (closing) begin
         if (set_items > 0 && set_min <= set_max) begin
            remaining = set_items;
            for (int b = set_min; b <= set_max; b++) begin
               for (int c = 0; c < bin_count[b]; c++) begin
                  remaining--;
                  item.value   = OUT_BITS'(b);
                  item.last    = (remaining == 0);
                  item.dropped = set_overflow;
                  sorted_queue.push_back(item);
               end
            end
         end
         foreach (bin_count[i]) bin_count[i] = '0;
         set_min      = '1;
         set_max      = '0;
         set_items    = 0;
         set_overflow = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         absorb_value(req_value, req_last);
   end

   always @(posedge clock) begin : rsp_check
      sorted_item_type exp_item;
      if (!reset && rsp_valid && rsp_ready) begin
         if (sorted_queue.size() == 0) begin
            sort_errors++;
            if (sort_errors <= MAX_REPORTS)
               $display("unexpected response: value %0d last %0b dropped %0b",
                        rsp_value_res, rsp_last_res, rsp_dropped);
         end else begin
            exp_item = sorted_queue.pop_front();
            if (rsp_value_res !== exp_item.value || rsp_last_res !== exp_item.last ||
                rsp_dropped !== exp_item.dropped) begin
               sort_errors++;
               if (sort_errors <= MAX_REPORTS)
                  $display("mismatch: exp value %0d last %0b dropped %0b, got %0d %0b %0b",
                           exp_item.value, exp_item.last, exp_item.dropped,
                           rsp_value_res, rsp_last_res, rsp_dropped);
            end
         end
      end
   end

   // response side: random idling, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left == 0 && hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("[counting_sort_engine_core] ERROR");
         $finish;
      end
   end

   // offer one transaction; returns on the edge at which it is accepted
   task automatic send_value(input logic [IN_BITS-1:0] v, input logic closing);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= closing;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_set(input value_q_type vals);
      foreach (vals[i]) send_value(vals[i], i == vals.size() - 1);
   endtask

   // sender pauses until every queued result has come back
   task automatic drain_sorted();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sorted_queue.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_sets();
      req_idle_pct = 38;
      rsp_idle_pct = 66;
      send_set('{8'd0});
      send_set('{8'd255});
      send_set('{8'd255, 8'd0});
      send_set('{8'd9, 8'd9, 8'd9, 8'd9});
      send_set('{8'd0, 8'd128, 8'd255, 8'd128});
      send_set('{8'd200, 8'd3, 8'd200, 8'd3, 8'd17});
   endtask

   // long response stall while a short set emits and an overflowing set
   // queues up behind it; the last two values of the big set are the dropped ones
   task automatic test_backpressure_overflow();
      value_q_type big_set;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_request = 300;
      send_set('{8'd40, 8'd2, 8'd40, 8'd77, 8'd1});
      for (int i = 0; i < MAX_ITEMS + 2; i++) big_set.push_back(IN_BITS'($urandom_range(63)));
      send_set(big_set);
      drain_sorted();
      // exactly full set, closing value still loaded
      big_set.delete();
      for (int i = 0; i < MAX_ITEMS; i++) big_set.push_back(IN_BITS'($urandom_range(255)));
      send_set(big_set);
   endtask

   task automatic test_random_sets(input int unsigned send_pct, input int unsigned recv_pct,
                                   input int unsigned budget);
      int unsigned           sent;
      int unsigned           set_len;
      int unsigned           spread;
      logic [IN_BITS-1:0]    base;
      logic [IN_BITS-1:0]    v;
      req_idle_pct = send_pct;
      rsp_idle_pct = recv_pct;
      sent = 0;
      while (sent < budget) begin
         set_len = ($urandom_range(14) == 0) ? $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6)
                                             : $urandom_range(1, 8);
         if (set_len > budget - sent)
            set_len = budget - sent;
         spread  = $urandom_range(2);
         base    = IN_BITS'($urandom_range(255));
         for (int i = 0; i < set_len; i++) begin
            case (spread)
               0: v = IN_BITS'($urandom_range(255));
               1: v = base + IN_BITS'($urandom_range(7));   // narrow span, short scan, unless it wraps past 255
               default: v = $urandom_range(1) ? '1 : '0;
            endcase
            send_value(v, i == set_len - 1);
         end
         sent += set_len;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_sets();
      test_backpressure_overflow();
      drain_sorted();
      test_random_sets(38, 66, 20);
      test_random_sets(66, 38, 20);
      test_random_sets(0, 0, 20);
      drain_sorted();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sort_errors == 0 && sorted_queue.size() == 0) begin
         $display("[counting_sort_engine_core] OK");
      end else begin
         $display("[counting_sort_engine_core] ERROR");
      end
      $finish;
   end

endmodule
